// ----- rtl/line_rasterizer_macros.svh -----
// Assertion macros shared by the line rasterizer RTL.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define LR_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define LR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lr_pkg.sv -----
// Shared types and constants for the line rasterizer.
// Used by every module of the block; depends on nothing.
package lr_pkg;

	localparam int COORD_BITS_DEF  = 12;
	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [0:0] {
		CMD_START   = 1'b0,
		CMD_ADVANCE = 1'b1
	} cmd_t;

	typedef logic signed [1:0] step_t;

	// Control part of one queued command.
	typedef struct packed {
		cmd_t  op;
		logic  steep;
		step_t step_x;
		step_t step_y;
	} line_ctrl_t;

	localparam int CTRL_W = $bits(line_ctrl_t);

endpackage

// ----- rtl/lr_front.sv -----
// Front end of the line rasterizer: accepts command beats and classifies them.
// Two pipeline stages compute deltas, signs, axis order and decision terms.
// Depends on lr_pkg.
module lr_front #(
	parameter int COORD_BITS  = lr_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = lr_pkg::QUEUE_DEPTH_DEF,
	localparam int DEC_W      = COORD_BITS + 3,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic                          cmd,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  end_x,
	input  logic signed [COORD_BITS-1:0]  end_y,
	input  logic [CNT_W-1:0]              q_count,
	output logic [1:0]                    inflight,
	output logic                          wr_valid,
	output lr_pkg::line_ctrl_t            wr_ctrl,
	output logic signed [COORD_BITS-1:0]  wr_x0,
	output logic signed [COORD_BITS-1:0]  wr_y0,
	output logic [COORD_BITS-1:0]         wr_steps,
	output logic signed [DEC_W-1:0]       wr_dec,
	output logic signed [DEC_W-1:0]       wr_inc_ortho,
	output logic signed [DEC_W-1:0]       wr_inc_diag
);
	import lr_pkg::*;

	logic                         accept;
	logic [CNT_W:0]               reserved;

	logic                         valid_s1;
	cmd_t                         op_s1;
	logic signed [COORD_BITS-1:0] x0_s1;
	logic signed [COORD_BITS-1:0] y0_s1;
	logic signed [COORD_BITS:0]   dx_s1;
	logic signed [COORD_BITS:0]   dy_s1;

	logic                         valid_s2;
	cmd_t                         op_s2;
	logic signed [COORD_BITS-1:0] x0_s2;
	logic signed [COORD_BITS-1:0] y0_s2;
	logic [COORD_BITS-1:0]        adx_s2;
	logic [COORD_BITS-1:0]        ady_s2;
	step_t                        sx_s2;
	step_t                        sy_s2;

	logic signed [COORD_BITS:0]   neg_dx;
	logic signed [COORD_BITS:0]   neg_dy;
	logic                         steep;
	logic [COORD_BITS-1:0]        major;
	logic [COORD_BITS-1:0]        minor;
	logic signed [DEC_W-1:0]      major_ext;
	logic signed [DEC_W-1:0]      minor_ext;

	// Room is reserved in the queue for every beat still in the two stages.
	assign inflight  = {1'b0, valid_s1} + {1'b0, valid_s2};
	assign reserved  = {1'b0, q_count} + (CNT_W + 1)'(inflight);
	assign cmd_stall = reserved >= (CNT_W + 1)'(QUEUE_DEPTH);
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= cmd_t'(cmd);
			x0_s1 <= start_x;
			y0_s1 <= start_y;
			dx_s1 <= {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
			dy_s1 <= {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
		end
	end

	assign neg_dx = -dx_s1;
	assign neg_dy = -dy_s1;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			op_s2  <= op_s1;
			x0_s2  <= x0_s1;
			y0_s2  <= y0_s1;
			adx_s2 <= dx_s1[COORD_BITS] ? neg_dx[COORD_BITS-1:0] : dx_s1[COORD_BITS-1:0];
			ady_s2 <= dy_s1[COORD_BITS] ? neg_dy[COORD_BITS-1:0] : dy_s1[COORD_BITS-1:0];
			sx_s2  <= (dx_s1 == '0) ? step_t'(0) : (dx_s1[COORD_BITS] ? step_t'(-1) : step_t'(1));
			sy_s2  <= (dy_s1 == '0) ? step_t'(0) : (dy_s1[COORD_BITS] ? step_t'(-1) : step_t'(1));
		end
	end

	// Steep lines swap the axes so that the major axis always has the larger delta.
	assign steep     = ady_s2 > adx_s2;
	assign major     = steep ? ady_s2 : adx_s2;
	assign minor     = steep ? adx_s2 : ady_s2;
	assign major_ext = {{(DEC_W - COORD_BITS){1'b0}}, major};
	assign minor_ext = {{(DEC_W - COORD_BITS){1'b0}}, minor};

	assign wr_valid       = valid_s2;
	assign wr_ctrl.op     = op_s2;
	assign wr_ctrl.steep  = steep;
	assign wr_ctrl.step_x = sx_s2;
	assign wr_ctrl.step_y = sy_s2;
	assign wr_x0          = x0_s2;
	assign wr_y0          = y0_s2;
	assign wr_steps       = major;
	assign wr_inc_ortho   = minor_ext <<< 1;
	assign wr_dec         = (minor_ext <<< 1) - major_ext;
	assign wr_inc_diag    = (minor_ext - major_ext) <<< 1;

endmodule

// ----- rtl/lr_queue.sv -----
// Small first-in first-out queue between the front and back of the rasterizer.
// Register-file storage with combinational head read; depends on lr_pkg.
module lr_queue #(
	parameter int WIDTH       = 8,
	parameter int QUEUE_DEPTH = lr_pkg::QUEUE_DEPTH_DEF,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
	localparam int PTR_W      = $clog2(QUEUE_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic             rd_valid,
	output logic [WIDTH-1:0] rd_data,
	output logic [CNT_W-1:0] count
);
	import lr_pkg::*;

	logic [WIDTH-1:0] mem [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_valid = count_q != '0;
	assign rd_data  = mem[rd_ptr_q];
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/lr_back.sv -----
// Back end of the line rasterizer: line state and the pixel output register.
// Runs one queued command per cycle while the pixel output is not stalled; depends on lr_pkg.
module lr_back #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF,
	localparam int DEC_W     = COORD_BITS + 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  lr_pkg::line_ctrl_t            q_ctrl,
	input  logic signed [COORD_BITS-1:0]  q_x0,
	input  logic signed [COORD_BITS-1:0]  q_y0,
	input  logic [COORD_BITS-1:0]         q_steps,
	input  logic signed [DEC_W-1:0]       q_dec,
	input  logic signed [DEC_W-1:0]       q_inc_ortho,
	input  logic signed [DEC_W-1:0]       q_inc_diag,
	output logic                          pix_valid,
	input  logic                          pix_stall,
	output logic signed [COORD_BITS-1:0]  pixel_x,
	output logic signed [COORD_BITS-1:0]  pixel_y,
	output logic                          last,
	output logic                          fresh
);
	import lr_pkg::*;

	logic signed [COORD_BITS-1:0] cur_x_q;
	logic signed [COORD_BITS-1:0] cur_y_q;
	logic signed [DEC_W-1:0]      dec_q;
	logic signed [DEC_W-1:0]      inc_ortho_q;
	logic signed [DEC_W-1:0]      inc_diag_q;
	logic [COORD_BITS-1:0]        steps_q;
	step_t                        step_x_q;
	step_t                        step_y_q;
	logic                         steep_q;

	logic                         pix_valid_q;
	logic signed [COORD_BITS-1:0] pixel_x_q;
	logic signed [COORD_BITS-1:0] pixel_y_q;
	logic                         last_q;
	logic                         fresh_q;

	logic                         diag;
	logic                         done;
	logic signed [COORD_BITS-1:0] next_x;
	logic signed [COORD_BITS-1:0] next_y;
	logic signed [DEC_W-1:0]      next_dec;

	assign q_pop = q_valid && (!pix_valid_q || !pix_stall);
	assign done  = steps_q == '0;
	assign diag  = !dec_q[DEC_W-1];

	always_comb begin
		next_x   = cur_x_q;
		next_y   = cur_y_q;
		if (diag || !steep_q) begin
			next_x = cur_x_q + {{(COORD_BITS - 2){step_x_q[1]}}, step_x_q};
		end
		if (diag || steep_q) begin
			next_y = cur_y_q + {{(COORD_BITS - 2){step_y_q[1]}}, step_y_q};
		end
		next_dec = dec_q + (diag ? inc_diag_q : inc_ortho_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			dec_q       <= '0;
			inc_ortho_q <= '0;
			inc_diag_q  <= '0;
			steps_q     <= '0;
			step_x_q    <= '0;
			step_y_q    <= '0;
			steep_q     <= 1'b0;
		end else if (q_pop) begin
			case (q_ctrl.op)
				CMD_START: begin
					cur_x_q     <= q_x0;
					cur_y_q     <= q_y0;
					dec_q       <= q_dec;
					inc_ortho_q <= q_inc_ortho;
					inc_diag_q  <= q_inc_diag;
					steps_q     <= q_steps;
					step_x_q    <= q_ctrl.step_x;
					step_y_q    <= q_ctrl.step_y;
					steep_q     <= q_ctrl.steep;
				end
				CMD_ADVANCE: begin
					if (!done) begin
						cur_x_q <= next_x;
						cur_y_q <= next_y;
						dec_q   <= next_dec;
						steps_q <= steps_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (q_pop) begin
			pix_valid_q <= 1'b1;
		end else if (!pix_stall) begin
			pix_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			case (q_ctrl.op)
				CMD_START: begin
					pixel_x_q <= q_x0;
					pixel_y_q <= q_y0;
					last_q    <= q_steps == '0;
					fresh_q   <= 1'b1;
				end
				CMD_ADVANCE: begin
					if (done) begin
						pixel_x_q <= cur_x_q;
						pixel_y_q <= cur_y_q;
						last_q    <= 1'b1;
						fresh_q   <= 1'b0;
					end else begin
						pixel_x_q <= next_x;
						pixel_y_q <= next_y;
						last_q    <= steps_q == COORD_BITS'(1);
						fresh_q   <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign pix_valid = pix_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign last      = last_q;
	assign fresh     = fresh_q;

endmodule

// ----- rtl/line_rasterizer.sv -----
// Top level of the Bresenham line rasterizer (all eight octants).
// Instantiates lr_front, lr_queue and lr_back; depends on lr_pkg and the macro header.
//
//   channel   dir  handshake              payload
//   command   in   cmd_valid / cmd_stall  cmd, start_x, start_y, end_x, end_y
//   pixel     out  pix_valid / pix_stall  pixel_x, pixel_y, last, fresh
//
// Every command beat yields exactly one pixel beat, one per clock sustained while the pixel side does not stall.
// From command accept to pixel valid a beat passes through the two front stages
// and the queue, after which the back end's output register holds the pixel.
// The back end updates the line state once per beat, which sets the rate.
// Reset (arst_n, asynchronous, active low) clears the line state to zero.
// A pixel stall holds the output register and backs up into the queue; the
// command side stalls only when the queue has no room left for its in-flight beats.
`include "line_rasterizer_macros.svh"

module line_rasterizer #(
	parameter int COORD_BITS  = lr_pkg::COORD_BITS_DEF,
	parameter int QUEUE_DEPTH = lr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic                          cmd,
	input  logic signed [COORD_BITS-1:0]  start_x,
	input  logic signed [COORD_BITS-1:0]  start_y,
	input  logic signed [COORD_BITS-1:0]  end_x,
	input  logic signed [COORD_BITS-1:0]  end_y,
	output logic                          pix_valid,
	input  logic                          pix_stall,
	output logic signed [COORD_BITS-1:0]  pixel_x,
	output logic signed [COORD_BITS-1:0]  pixel_y,
	output logic                          last,
	output logic                          fresh
);
	import lr_pkg::*;

	// The decision value needs three bits beyond a coordinate: it ranges over
	// roughly minus twice the major delta to plus twice the minor delta.
	localparam int DEC_W   = COORD_BITS + 3;
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ENTRY_W = CTRL_W + 3 * COORD_BITS + 3 * DEC_W;

	// Front to queue.
	logic                         wr_valid;
	line_ctrl_t                   wr_ctrl;
	logic signed [COORD_BITS-1:0] wr_x0;
	logic signed [COORD_BITS-1:0] wr_y0;
	logic [COORD_BITS-1:0]        wr_steps;
	logic signed [DEC_W-1:0]      wr_dec;
	logic signed [DEC_W-1:0]      wr_inc_ortho;
	logic signed [DEC_W-1:0]      wr_inc_diag;
	logic [1:0]                   inflight;

	// Queue to back.
	logic [ENTRY_W-1:0]           wr_entry;
	logic [ENTRY_W-1:0]           rd_entry;
	logic [CNT_W-1:0]             q_count;
	logic                         q_valid;
	logic                         q_pop;
	line_ctrl_t                   rd_ctrl;
	logic signed [COORD_BITS-1:0] rd_x0;
	logic signed [COORD_BITS-1:0] rd_y0;
	logic [COORD_BITS-1:0]        rd_steps;
	logic signed [DEC_W-1:0]      rd_dec;
	logic signed [DEC_W-1:0]      rd_inc_ortho;
	logic signed [DEC_W-1:0]      rd_inc_diag;

	// The front computes deltas and signs, picks the major axis and prepares
	// the initial decision value and both increments for start commands.
	lr_front #(
		.COORD_BITS  (COORD_BITS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd          (cmd),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.q_count      (q_count),
		.inflight     (inflight),
		.wr_valid     (wr_valid),
		.wr_ctrl      (wr_ctrl),
		.wr_x0        (wr_x0),
		.wr_y0        (wr_y0),
		.wr_steps     (wr_steps),
		.wr_dec       (wr_dec),
		.wr_inc_ortho (wr_inc_ortho),
		.wr_inc_diag  (wr_inc_diag)
	);

	assign wr_entry = {wr_ctrl, wr_x0, wr_y0, wr_steps, wr_dec, wr_inc_ortho, wr_inc_diag};

	lr_queue #(
		.WIDTH       (ENTRY_W),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_valid),
		.wr_data  (wr_entry),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_data  (rd_entry),
		.count    (q_count)
	);

	assign {rd_ctrl, rd_x0, rd_y0, rd_steps, rd_dec, rd_inc_ortho, rd_inc_diag} = rd_entry;

	// The back end owns the current pixel and decision value. Advances on a
	// finished line repeat the endpoint with fresh low and leave the state alone.
	lr_back #(
		.COORD_BITS (COORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_ctrl      (rd_ctrl),
		.q_x0        (rd_x0),
		.q_y0        (rd_y0),
		.q_steps     (rd_steps),
		.q_dec       (rd_dec),
		.q_inc_ortho (rd_inc_ortho),
		.q_inc_diag  (rd_inc_diag),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.last        (last),
		.fresh       (fresh)
	);

	// Beats in the front stages plus queued beats never exceed the queue depth,
	// so the front never has to hold a beat back.
	`LR_ASSERT_ALWAYS(a_room_reserved, ({1'b0, q_count} + (CNT_W + 1)'(inflight)) <= (CNT_W + 1)'(QUEUE_DEPTH), "queue overcommitted")

	// A queued beat with a free output register shows up as a pixel next cycle.
	`LR_ASSERT_NEXT(a_pop_to_pixel, q_valid && !(pix_valid && pix_stall), pix_valid, "queued beat not delivered")

	// A repeated pixel is always the final endpoint of its line.
	`LR_ASSERT_ALWAYS(a_repeat_is_last, !(pix_valid && !fresh) || last, "repeat pixel without last")

endmodule

// ----- test/line_rasterizer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for line_rasterizer: drives command beats, predicts every pixel beat.
// Depends on lr_pkg and the line_rasterizer RTL; needs no files or arguments.
module line_rasterizer_tb;
	import lr_pkg::*;

	localparam int CW = COORD_BITS_DEF;
	// The decision term carries three bits more than a coordinate.
	localparam int DW = CW + 3;
	// Minimum number of random command beats after the directed part.
	localparam int RANDOM_BEATS = 1600;
	// Cycles with no beat on either channel before the run is declared hung.
	localparam int IDLE_LIMIT = 3000;
	// Cycles to keep watching the pixel channel once nothing is expected.
	localparam int DRAIN_CYCLES = 12;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
		logic   fresh;
	} pixel_beat_t;

	// Line walker model plus the queue of pixel beats that are owed by the block.
	class line_scoreboard;
		coord_t         pos_x;
		coord_t         pos_y;
		logic signed [DW-1:0] err_term;
		logic [CW-1:0]  remaining;
		logic [CW-1:0]  major_d;
		logic [CW-1:0]  minor_d;
		step_t          dir_x;
		step_t          dir_y;
		logic           y_major;
		pixel_beat_t    owed_pixels[$];
		int             errors;

		function new();
			pos_x     = '0;
			pos_y     = '0;
			err_term  = '0;
			remaining = '0;
			major_d   = '0;
			minor_d   = '0;
			dir_x     = '0;
			dir_y     = '0;
			y_major   = 1'b0;
			errors    = 0;
		endfunction

		function int pending();
			return owed_pixels.size();
		endfunction

		task report(string msg);
			errors++;
			$display("MISMATCH @%0t: %s", $realtime, msg);
		endtask

		function void push_pixel(logic is_last, logic is_fresh);
			pixel_beat_t p;
			p.x     = pos_x;
			p.y     = pos_y;
			p.last  = is_last;
			p.fresh = is_fresh;
			owed_pixels.push_back(p);
		endfunction

		// Advance the model by one accepted command beat and queue the pixel it yields.
		function void note_command(cmd_t op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
			int ddx;
			int ddy;
			int adx;
			int ady;
			int upd;
			if (op == CMD_START) begin
				ddx = int'(ex) - int'(sx);
				ddy = int'(ey) - int'(sy);
				adx = (ddx < 0) ? -ddx : ddx;
				ady = (ddy < 0) ? -ddy : ddy;
				pos_x   = sx;
				pos_y   = sy;
				dir_x   = (ddx > 0) ? 2'sd1 : (ddx < 0) ? -2'sd1 : 2'sd0;
				dir_y   = (ddy > 0) ? 2'sd1 : (ddy < 0) ? -2'sd1 : 2'sd0;
				// Ties between the deltas keep x as the major axis.
				y_major = (ady > adx);
				major_d = y_major ? CW'(ady) : CW'(adx);
				minor_d = y_major ? CW'(adx) : CW'(ady);
				err_term  = DW'(2 * int'(minor_d) - int'(major_d));
				remaining = major_d;
				push_pixel(remaining == '0, 1'b1);
			end else if (remaining == '0) begin
				// Line finished (or never started): repeat the endpoint as a stale pixel.
				push_pixel(1'b1, 1'b0);
			end else begin
				if (err_term >= 0) begin
					pos_x = pos_x + dir_x;
					pos_y = pos_y + dir_y;
					upd   = 2 * (int'(minor_d) - int'(major_d));
				end else begin
					if (y_major)
						pos_y = pos_y + dir_y;
					else
						pos_x = pos_x + dir_x;
					upd = 2 * int'(minor_d);
				end
				err_term  = DW'(int'(err_term) + upd);
				remaining = remaining - 1'b1;
				push_pixel(remaining == '0, 1'b1);
			end
		endfunction

		task check_pixel(coord_t x, coord_t y, logic is_last, logic is_fresh);
			pixel_beat_t want;
			if (owed_pixels.size() == 0) begin
				report($sformatf("pixel beat (%0d,%0d) with nothing owed", x, y));
			end else begin
				want = owed_pixels.pop_front();
				if (x !== want.x)
					report($sformatf("pixel_x %0d, predicted %0d", x, want.x));
				if (y !== want.y)
					report($sformatf("pixel_y %0d, predicted %0d", y, want.y));
				if (is_last !== want.last)
					report($sformatf("last %b, predicted %b at (%0d,%0d)",
						is_last, want.last, want.x, want.y));
				if (is_fresh !== want.fresh)
					report($sformatf("fresh %b, predicted %b at (%0d,%0d)",
						is_fresh, want.fresh, want.x, want.y));
			end
		endtask
	endclass

	// Every input starts at a known value at time zero.
	logic   clk       = 1'b0;
	logic   arst_n    = 1'b0;
	logic   cmd_valid = 1'b0;
	logic   cmd       = CMD_START;
	coord_t start_x   = '0;
	coord_t start_y   = '0;
	coord_t end_x     = '0;
	coord_t end_y     = '0;
	logic   pix_stall = 1'b0;

	logic   cmd_stall;
	logic   pix_valid;
	coord_t pixel_x;
	coord_t pixel_y;
	logic   last;
	logic   fresh;

	line_scoreboard sb;
	int     beats_sent;
	int     idle_cycles;
	int     stall_left;
	int     phase_left;
	// While calm is set, neither side inserts new gaps or stalls; a stall burst already under way still runs out.
	logic   calm;

	line_rasterizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.last      (last),
		.fresh     (fresh)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Switch at random between stretches with random idling and stretches at full rate.
	initial begin
		calm       = 1'b0;
		phase_left = 200;
	end

	always @(posedge clk) begin
		if (phase_left == 0) begin
			calm       = ($urandom_range(0, 3) == 0);
			phase_left = $urandom_range(50, 400);
		end else begin
			phase_left--;
		end
	end

	// Pixel side back-pressure: mostly none, some short bursts, a few long ones.
	initial stall_left = 0;

	always @(posedge clk) begin
		int r;
		if (!arst_n) begin
			pix_stall <= 1'b0;
		end else if (stall_left > 0) begin
			pix_stall <= 1'b1;
			stall_left--;
		end else if (calm) begin
			pix_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 65) begin
				pix_stall <= 1'b0;
			end else if (r < 95) begin
				pix_stall  <= 1'b1;
				stall_left = $urandom_range(0, 2);
			end else begin
				pix_stall  <= 1'b1;
				stall_left = $urandom_range(9, 49);
			end
		end
	end

	// Both channels are sampled at the rising edge, before any of this edge's
	// updates land, so an accepted beat is seen exactly once. The command is
	// noted before the pixel is checked, though latency keeps them apart anyway.
	// The watchdog counts cycles in which neither channel moves a beat.
	initial idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall)
				sb.note_command(cmd_t'(cmd), start_x, start_y, end_x, end_y);
			if (pix_valid && !pix_stall)
				sb.check_pixel(pixel_x, pixel_y, last, fresh);
			if ((cmd_valid && !cmd_stall) || (pix_valid && !pix_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: no beat for %0d cycles", IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Gap ahead of a command beat: mostly none, some short, a few long.
	function int gap_cycles();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Drive one command beat and hold it until the block takes it. The task is
	// entered and left on a rising edge; valid is only lowered when a gap follows,
	// so it never gets two updates in one step.
	task send(cmd_t op, coord_t sx, coord_t sy, coord_t ex, coord_t ey);
		int gap;
		gap = gap_cycles();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= op;
		start_x   <= sx;
		start_y   <= sy;
		end_x     <= ex;
		end_y     <= ey;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		beats_sent++;
	endtask

	// An advance ignores its coordinates, so they carry random bits.
	task send_advance();
		send(CMD_ADVANCE, coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), coord_t'($urandom));
	endtask

	// A coordinate within a few units of either end of the range.
	function coord_t edge_coord();
		int r;
		r = $urandom_range(0, 15);
		return (r < 8) ? coord_t'(-2048 + r) : coord_t'(2047 - (r - 8));
	endfunction

	task run_directed();
		// Advance straight out of reset repeats pixel (0,0) as a stale endpoint.
		send_advance();
		send_advance();
		// Single-point line, then an advance past its end.
		send(CMD_START, 12'sd5, 12'sd5, 12'sd5, 12'sd5);
		send_advance();
		// Horizontal line to the right, walked one pixel past its end.
		send(CMD_START, 12'sd0, 12'sd0, 12'sd3, 12'sd0);
		repeat (4) send_advance();
		// Vertical line going down.
		send(CMD_START, 12'sd0, 12'sd0, 12'sd0, -12'sd2);
		repeat (2) send_advance();
		// Full-range diagonals in both directions, abandoned after a few pixels.
		send(CMD_START, -12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047);
		repeat (2) send_advance();
		send(CMD_START, 12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047);
		send_advance();
		// Single point at the top corner of the range.
		send(CMD_START, 12'sd2047, 12'sd2047, 12'sd2047, 12'sd2047);
		// Steep line heading left, walked to the end.
		send(CMD_START, 12'sd1, 12'sd2, -12'sd3, 12'sd7);
		repeat (5) send_advance();
		// Equal deltas at the range edge: x stays the major axis.
		send(CMD_START, -12'sd2048, 12'sd2047, -12'sd2045, 12'sd2044);
		repeat (4) send_advance();
	endtask

	// One random line, usually walked to its end and sometimes beyond it,
	// sometimes cut short by the next start.
	task run_line();
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		int     kind;
		int     adx;
		int     ady;
		int     len;
		int     walk;
		kind = $urandom_range(0, 99);
		sx   = coord_t'($urandom);
		sy   = coord_t'($urandom);
		if (kind < 55) begin
			ex = coord_t'(int'(sx) + $urandom_range(0, 30) - 15);
			ey = coord_t'(int'(sy) + $urandom_range(0, 30) - 15);
		end else if (kind < 75) begin
			// Near the range edges; a delta may wrap into a long line.
			sx = edge_coord();
			sy = edge_coord();
			ex = ($urandom_range(0, 1) == 0) ? edge_coord() :
				coord_t'(int'(sx) + $urandom_range(0, 20) - 10);
			ey = ($urandom_range(0, 1) == 0) ? edge_coord() :
				coord_t'(int'(sy) + $urandom_range(0, 20) - 10);
		end else if (kind < 90) begin
			ex = coord_t'(int'(sx) + $urandom_range(0, 400) - 200);
			ey = coord_t'(int'(sy) + $urandom_range(0, 400) - 200);
		end else begin
			ex = coord_t'($urandom);
			ey = coord_t'($urandom);
		end
		adx = int'(ex) - int'(sx);
		ady = int'(ey) - int'(sy);
		adx = (adx < 0) ? -adx : adx;
		ady = (ady < 0) ? -ady : ady;
		len = (adx > ady) ? adx : ady;
		if (len > 300)
			walk = $urandom_range(0, 40);
		else if ($urandom_range(0, 3) == 0)
			walk = $urandom_range(0, len);
		else
			walk = len + $urandom_range(0, 2);
		send(CMD_START, sx, sy, ex, ey);
		repeat (walk) send_advance();
	endtask

	task run_random();
		int target;
		target = beats_sent + RANDOM_BEATS;
		while (beats_sent < target) begin
			if ($urandom_range(0, 99) < 8)
				repeat ($urandom_range(1, 4)) send_advance();
			else
				run_line();
		end
	endtask

	initial begin
		sb         = new();
		beats_sent = 0;
		// Reset is asserted from time zero and released once, at a rising edge.
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random();
		cmd_valid <= 1'b0;
		// Wait for every owed pixel, then watch a little longer for strays.
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d pixel beats never arrived", sb.pending()));
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
